// ----- src/ternary_weight_int8_dot_product_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ternary weight dot product unit
// Each check is clocked on clock and turned off while reset is high.
// ----------------------------------------------------------------------------
`ifndef TERNARY_WEIGHT_INT8_DOT_PRODUCT_UNIT_DEFINES_SVH
`define TERNARY_WEIGHT_INT8_DOT_PRODUCT_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TWDP_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("twdp assertion failed");
`define TWDP_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("twdp forbidden condition seen");
`else
`define TWDP_ASSERT(lbl, prop)
`define TWDP_ASSERT_NEVER(lbl, cond)
`endif

`endif

// ----- src/twdp_pkg.sv -----
// ----------------------------------------------------------------------------
// twdp_pkg
// Shared types and constants of the ternary weight dot product unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package twdp_pkg;

   localparam int ACT_W     = 8;
   localparam int WEIGHT_W  = 8;
   localparam int NUM_LANES = 4;
   localparam int TRIT_W    = 2;
   localparam int PROD_W    = ACT_W + 1;
   localparam int TERM_W    = PROD_W + 2;
   localparam int SUM_W     = 25;
   localparam int SUM_EXT_W = SUM_W + 1;

   // trit codes
   localparam logic [TRIT_W-1:0] TRIT_NEG  = 2'b00;
   localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'b01;
   localparam logic [TRIT_W-1:0] TRIT_POS  = 2'b10;
   localparam logic [TRIT_W-1:0] TRIT_BAD  = 2'b11;

   // saturation bound
   localparam longint MAX_LEN   = 65536;
   localparam longint SUM_LIMIT = (longint'(1) <<< (SUM_W - 1)) - 1;
   localparam longint BOUND_RAW = MAX_LEN * 128;
   localparam longint BOUND     = (BOUND_RAW > SUM_LIMIT) ? SUM_LIMIT : BOUND_RAW;
   localparam logic signed [SUM_EXT_W-1:0] BOUND_POS = SUM_EXT_W'(BOUND);
   localparam logic signed [SUM_EXT_W-1:0] BOUND_NEG = SUM_EXT_W'(-BOUND);

   // queue between front and back
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic                     last;
      logic signed [TERM_W-1:0] term;
   } entry_type;

endpackage

`default_nettype wire

// ----- src/twdp_front.sv -----
// ----------------------------------------------------------------------------
// twdp_front
// Takes a request, decodes the four trits and folds the four signed
// activations into one partial term for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module twdp_front (
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [twdp_pkg::WEIGHT_W-1:0]         req_weight_byte,
   input  logic signed [twdp_pkg::ACT_W-1:0]     req_act0,
   input  logic signed [twdp_pkg::ACT_W-1:0]     req_act1,
   input  logic signed [twdp_pkg::ACT_W-1:0]     req_act2,
   input  logic signed [twdp_pkg::ACT_W-1:0]     req_act3,
   input  logic                                  req_last,
   input  logic                                  queue_full,
   output logic                                  push,
   output twdp_pkg::entry_type                   push_entry
);

   logic signed [twdp_pkg::PROD_W-1:0] act_ext  [twdp_pkg::NUM_LANES];
   logic signed [twdp_pkg::PROD_W-1:0] prod     [twdp_pkg::NUM_LANES];
   logic [twdp_pkg::TRIT_W-1:0]        code     [twdp_pkg::NUM_LANES];
   logic signed [twdp_pkg::TERM_W-1:0] term_sum;

   assign act_ext[0] = {req_act0[twdp_pkg::ACT_W-1], req_act0};
   assign act_ext[1] = {req_act1[twdp_pkg::ACT_W-1], req_act1};
   assign act_ext[2] = {req_act2[twdp_pkg::ACT_W-1], req_act2};
   assign act_ext[3] = {req_act3[twdp_pkg::ACT_W-1], req_act3};

   always_comb begin
      for (int i = 0; i < twdp_pkg::NUM_LANES; i++) begin
         code[i] = req_weight_byte[i*twdp_pkg::TRIT_W +: twdp_pkg::TRIT_W];
         case (code[i]) inside
            twdp_pkg::TRIT_NEG:                       prod[i] = -act_ext[i];
            twdp_pkg::TRIT_POS:                       prod[i] = act_ext[i];
            twdp_pkg::TRIT_ZERO, twdp_pkg::TRIT_BAD:  prod[i] = '0;
            default:                                  prod[i] = '0;
         endcase
      end
   end

   // lane sum, -512 .. +512
   always_comb begin
      term_sum = '0;
      for (int i = 0; i < twdp_pkg::NUM_LANES; i++) begin
         term_sum = term_sum + twdp_pkg::TERM_W'(prod[i]);
      end
   end

   assign req_stall       = queue_full;
   assign push            = req_valid & ~queue_full;
   assign push_entry.last = req_last;
   assign push_entry.term = term_sum;

endmodule

`default_nettype wire

// ----- src/twdp_queue.sv -----
// ----------------------------------------------------------------------------
// twdp_queue
// Short first-in first-out queue of decoded terms between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_weight_int8_dot_product_unit_defines.svh"

module twdp_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  twdp_pkg::entry_type push_entry,
   input  logic                pop,
   output twdp_pkg::entry_type pop_entry,
   output logic                not_empty,
   output logic                full
);

   twdp_pkg::entry_type                slot_ff [twdp_pkg::FIFO_DEPTH];
   logic [twdp_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [twdp_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [twdp_pkg::FIFO_CNT_W-1:0]    count_ff, count_in;

   assign full      = (count_ff == twdp_pkg::FIFO_CNT_W'(twdp_pkg::FIFO_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `TWDP_ASSERT_NEVER(a_push_when_full, push && full)
   `TWDP_ASSERT_NEVER(a_pop_when_empty, pop && !not_empty)
   `TWDP_ASSERT(a_count_tracks_ptrs,
      full || count_ff == twdp_pkg::FIFO_CNT_W'(twdp_pkg::FIFO_PTR_W'(wr_ptr_ff - rd_ptr_ff)))

endmodule

`default_nettype wire

// ----- src/twdp_back.sv -----
// ----------------------------------------------------------------------------
// twdp_back
// Drains the queue into the saturating running sum and holds the finished
// dot product in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "ternary_weight_int8_dot_product_unit_defines.svh"

module twdp_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                not_empty,
   input  twdp_pkg::entry_type                 pop_entry,
   output logic                                pop,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [twdp_pkg::SUM_W-1:0]   rsp_dot_sum
);

   logic signed [twdp_pkg::SUM_W-1:0]     acc_ff, acc_in;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic signed [twdp_pkg::SUM_W-1:0]     rsp_dot_sum_ff, rsp_dot_sum_in;
   logic signed [twdp_pkg::SUM_EXT_W-1:0] sum_wide;
   logic signed [twdp_pkg::SUM_W-1:0]     sum_sat;
   logic                                  slot_free;

   assign slot_free = ~rsp_valid_ff | ~rsp_stall;
   assign pop       = not_empty & (~pop_entry.last | slot_free);

   always_comb begin
      sum_wide = {acc_ff[twdp_pkg::SUM_W-1], acc_ff}
               + twdp_pkg::SUM_EXT_W'(pop_entry.term);
      if (sum_wide > twdp_pkg::BOUND_POS) begin
         sum_sat = twdp_pkg::SUM_W'(twdp_pkg::BOUND_POS);
      end else if (sum_wide < twdp_pkg::BOUND_NEG) begin
         sum_sat = twdp_pkg::SUM_W'(twdp_pkg::BOUND_NEG);
      end else begin
         sum_sat = sum_wide[twdp_pkg::SUM_W-1:0];
      end
   end

   always_comb begin
      acc_in         = acc_ff;
      rsp_valid_in   = rsp_valid_ff & rsp_stall;
      rsp_dot_sum_in = rsp_dot_sum_ff;
      if (pop) begin
         if (pop_entry.last) begin
            acc_in         = '0;
            rsp_valid_in   = 1'b1;
            rsp_dot_sum_in = sum_sat;
         end else begin
            acc_in = sum_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_dot_sum_ff <= rsp_dot_sum_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_dot_sum = rsp_dot_sum_ff;

   `TWDP_ASSERT(a_acc_in_bounds,
      $signed({acc_ff[twdp_pkg::SUM_W-1], acc_ff}) <= twdp_pkg::BOUND_POS &&
      $signed({acc_ff[twdp_pkg::SUM_W-1], acc_ff}) >= twdp_pkg::BOUND_NEG)
   `TWDP_ASSERT(a_last_clears_acc, pop && pop_entry.last |=> acc_ff == '0)
   `TWDP_ASSERT_NEVER(a_no_overwrite, pop && pop_entry.last && rsp_valid_ff && rsp_stall)

endmodule

`default_nettype wire

// ----- src/ternary_weight_int8_dot_product_unit.sv -----
// ----------------------------------------------------------------------------
// ternary_weight_int8_dot_product_unit
// Streaming dot product of 2-bit ternary weights with signed 8-bit
// activations, four elements per request, saturating 25-bit running sum.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the queue is not full: the front
// decodes the weight byte and adds the four signed activations into one
// term, a four-entry queue holds the terms, and the back adds one term per
// cycle into the running sum unless a stalled response holds a last term,
// clamped to +/- the bound after every term. The sum of a request flagged
// last passes through the queue into the response register, and the sum
// clears; while a response sits stalled, the back keeps absorbing requests
// that are not last and req_stall rises once the queue holds four entries. Trit code 11 counts as zero.
`timescale 1ns / 1ps
`default_nettype none

module ternary_weight_int8_dot_product_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [twdp_pkg::WEIGHT_W-1:0]       req_weight_byte,
   input  logic signed [twdp_pkg::ACT_W-1:0]   req_act0,
   input  logic signed [twdp_pkg::ACT_W-1:0]   req_act1,
   input  logic signed [twdp_pkg::ACT_W-1:0]   req_act2,
   input  logic signed [twdp_pkg::ACT_W-1:0]   req_act3,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [twdp_pkg::SUM_W-1:0]   rsp_dot_sum
);

   logic                push;
   logic                pop;
   logic                queue_full;
   logic                queue_not_empty;
   twdp_pkg::entry_type push_entry;
   twdp_pkg::entry_type pop_entry;

   twdp_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_weight_byte (req_weight_byte),
      .req_act0        (req_act0),
      .req_act1        (req_act1),
      .req_act2        (req_act2),
      .req_act3        (req_act3),
      .req_last        (req_last),
      .queue_full      (queue_full),
      .push            (push),
      .push_entry      (push_entry)
   );

   twdp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .not_empty  (queue_not_empty),
      .full       (queue_full)
   );

   twdp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .not_empty   (queue_not_empty),
      .pop_entry   (pop_entry),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_dot_sum (rsp_dot_sum)
   );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ternary weight int8 dot product unit. A queue
// of requests (directed corner cases and random vectors) feeds a clocked
// driver with random gaps. A clocked monitor stalls responses at random and
// checks each dot_sum against a predictor that tracks the running sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   localparam int SAT_BOUND = int'(twdp_pkg::BOUND);

   typedef struct packed {
      logic [twdp_pkg::WEIGHT_W-1:0]     weight;
      logic signed [twdp_pkg::ACT_W-1:0] act0;
      logic signed [twdp_pkg::ACT_W-1:0] act1;
      logic signed [twdp_pkg::ACT_W-1:0] act2;
      logic signed [twdp_pkg::ACT_W-1:0] act3;
      logic                              last;
      logic                              hold_off;
   } dot_req_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [twdp_pkg::WEIGHT_W-1:0]     req_weight_byte = '0;
   logic signed [twdp_pkg::ACT_W-1:0] req_act0 = '0;
   logic signed [twdp_pkg::ACT_W-1:0] req_act1 = '0;
   logic signed [twdp_pkg::ACT_W-1:0] req_act2 = '0;
   logic signed [twdp_pkg::ACT_W-1:0] req_act3 = '0;
   logic                              req_last = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [twdp_pkg::SUM_W-1:0] rsp_dot_sum;

   dot_req_type                       pending_reqs[$];
   logic signed [twdp_pkg::SUM_W-1:0] exp_dot_sums[$];
   dot_req_type                       cur_req;
   int                                vector_sum = 0;
   int                                fail_count = 0;
   int                                tx_gap = 0;
   int                                rx_hold = 0;
   bit                                tx_steady = 1'b0;
   bit                                rx_steady = 1'b0;

   ternary_weight_int8_dot_product_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_weight_byte (req_weight_byte),
      .req_act0        (req_act0),
      .req_act1        (req_act1),
      .req_act2        (req_act2),
      .req_act3        (req_act3),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dot_sum     (rsp_dot_sum)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic int lane_term(logic [twdp_pkg::TRIT_W-1:0] code,
                                    logic signed [twdp_pkg::ACT_W-1:0] act);
      case (code)
         twdp_pkg::TRIT_NEG: return -int'(act);
         twdp_pkg::TRIT_POS: return int'(act);
         default:            return 0;
      endcase
   endfunction

   task automatic absorb_request(dot_req_type r);
      int                                acc;
      logic signed [twdp_pkg::SUM_W-1:0] sum_out;
      acc = vector_sum + lane_term(r.weight[1:0], r.act0) + lane_term(r.weight[3:2], r.act1)
            + lane_term(r.weight[5:4], r.act2) + lane_term(r.weight[7:6], r.act3);
      if (acc > SAT_BOUND) begin
         acc = SAT_BOUND;
      end else if (acc < -SAT_BOUND) begin
         acc = -SAT_BOUND;
      end
      if (r.last) begin
         sum_out = acc[twdp_pkg::SUM_W-1:0];
         exp_dot_sums.push_back(sum_out);
         vector_sum = 0;
      end else begin
         vector_sum = acc;
      end
   endtask

   function automatic int idle_len(inout bit steady);
      int r;
      if ($urandom_range(0, 63) == 0) begin
         steady = ~steady;
      end
      if (steady) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(13, 40);
   endfunction

   function automatic logic signed [twdp_pkg::ACT_W-1:0] rand_act();
      case ($urandom_range(0, 7))
         0:       return 8'sh80;
         1:       return 8'sh7f;
         default: return twdp_pkg::ACT_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_req(logic [twdp_pkg::WEIGHT_W-1:0] w, logic signed [twdp_pkg::ACT_W-1:0] a0,
                          logic signed [twdp_pkg::ACT_W-1:0] a1,
                          logic signed [twdp_pkg::ACT_W-1:0] a2,
                          logic signed [twdp_pkg::ACT_W-1:0] a3, logic last, logic hold_off);
      dot_req_type r;
      r.weight   = w;
      r.act0     = a0;
      r.act1     = a1;
      r.act2     = a2;
      r.act3     = a3;
      r.last     = last;
      r.hold_off = hold_off;
      pending_reqs.push_back(r);
   endtask

   task automatic note_failure(string msg);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", msg);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            absorb_request(cur_req);
         end
         if (!req_valid || !req_stall) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_reqs[0].hold_off && exp_dot_sums.size() != 0) begin
               req_valid <= 1'b0;
            end else begin
               cur_req = pending_reqs.pop_front();
               req_weight_byte <= cur_req.weight;
               req_act0        <= cur_req.act0;
               req_act1        <= cur_req.act1;
               req_act2        <= cur_req.act2;
               req_act3        <= cur_req.act3;
               req_last        <= cur_req.last;
               req_valid       <= 1'b1;
               tx_gap = idle_len(tx_steady);
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      logic signed [twdp_pkg::SUM_W-1:0] want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (exp_dot_sums.size() == 0) begin
               note_failure($sformatf("unexpected response, dot_sum %0d", rsp_dot_sum));
            end else begin
               want = exp_dot_sums.pop_front();
               if (rsp_dot_sum !== want) begin
                  note_failure($sformatf("dot_sum mismatch: expected %0d, got %0d",
                                         want, rsp_dot_sum));
               end
            end
         end
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            rx_hold = idle_len(rx_steady);
         end
      end
   end

   initial begin
      int n;
      int len;
      int k;

      // corner cases, mostly one-request vectors, some spanning several requests
      add_req(8'h00, 8'sh80, 8'sh80, 8'sh80, 8'sh80, 1'b1, 1'b0);
      add_req(8'hAA, 8'sh80, 8'sh80, 8'sh80, 8'sh80, 1'b1, 1'b0);
      add_req(8'h00, 8'sh7f, 8'sh7f, 8'sh7f, 8'sh7f, 1'b1, 1'b0);
      add_req(8'hAA, 8'sh7f, 8'sh7f, 8'sh7f, 8'sh7f, 1'b1, 1'b0);
      add_req(8'h55, 8'sh7f, 8'sh80, 8'sh7f, 8'sh80, 1'b1, 1'b0);
      add_req(8'hFF, 8'sh80, 8'sh7f, 8'sh80, 8'sh7f, 1'b1, 1'b0);
      add_req(8'hE4, 8'sh0a, 8'sh14, 8'sh1e, 8'sh28, 1'b0, 1'b0);
      add_req(8'h1B, 8'sh01, 8'sh02, 8'sh03, 8'sh04, 1'b1, 1'b0);
      add_req(8'hC6, 8'sh80, 8'sh7f, 8'sh80, 8'sh7f, 1'b1, 1'b1);
      add_req(8'h39, 8'shff, 8'sh00, 8'sh01, 8'shfe, 1'b0, 1'b0);
      add_req(8'h00, 8'sh00, 8'sh00, 8'sh00, 8'sh00, 1'b0, 1'b0);
      add_req(8'hAA, 8'sh55, 8'shaa, 8'sh33, 8'shcc, 1'b0, 1'b0);
      add_req(8'h66, 8'sh80, 8'sh80, 8'sh80, 8'sh80, 1'b0, 1'b0);
      add_req(8'h99, 8'sh7f, 8'sh7f, 8'sh7f, 8'sh7f, 1'b1, 1'b0);
      add_req(8'h00, 8'sh80, 8'sh80, 8'sh80, 8'sh80, 1'b0, 1'b0);
      add_req(8'hAA, 8'sh80, 8'sh80, 8'sh80, 8'sh80, 1'b1, 1'b0);

      // random vectors, mostly short
      n = 0;
      while (n < 1400) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
         for (k = 0; k < len; k++) begin
            add_req(twdp_pkg::WEIGHT_W'($urandom_range(0, 255)),
                    rand_act(), rand_act(), rand_act(), rand_act(),
                    k == len - 1, k == 0 && (n == 0 || $urandom_range(0, 99) == 0));
         end
         n += len;
      end

      @(negedge reset);
      while (pending_reqs.size() != 0 || req_valid) begin
         @(negedge clock);
      end
      while (exp_dot_sums.size() != 0) begin
         @(negedge clock);
      end
      repeat (20) @(posedge clock);
      if (exp_dot_sums.size() != 0) begin
         note_failure($sformatf("%0d responses never arrived", exp_dot_sums.size()));
      end
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
